// ----- sv/svps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svps_pkg
// shared types, codes and reset values of the supply voltage supervisor
// ----------------------------------------------------------------------------
package svps_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ADC_BITS_DEF = 12;
  localparam int CFG_IDX_W = 3;
  localparam int ACT_W = 3;
  localparam int WS_W = 3;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_BOTTOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID   = 3'd5;

  localparam sample_t RST_MIN_VALID   = 12'd683;
  localparam sample_t RST_LOW_TOP     = 12'd956;
  localparam sample_t RST_FULL_BOTTOM = 12'd1161;
  localparam sample_t RST_FULL_TOP    = 12'd2485;
  localparam sample_t RST_HIGH_BOTTOM = 12'd2553;
  localparam sample_t RST_MAX_VALID   = 12'd3618;

  typedef struct packed {
    sample_t min_valid;
    sample_t low_top;
    sample_t full_bottom;
    sample_t full_top;
    sample_t high_bottom;
    sample_t max_valid;
  } thr_t;

  typedef enum logic [1:0] {
    LV_FULL = 2'd0,
    LV_LOW  = 2'd1,
    LV_HIGH = 2'd2,
    LV_ABN  = 2'd3
  } level_t;

  // band sort result: a level, or keep the last one
  typedef struct packed {
    logic   keep;
    level_t level;
  } band_t;

  typedef enum logic [4:0] {
    PH_ACTIVE   = 5'b00001,
    PH_TO_SBY   = 5'b00010,
    PH_ENTERING = 5'b00100,
    PH_STANDBY  = 5'b01000,
    PH_TO_ACT   = 5'b10000
  } phase_t;

  localparam logic [WS_W-1:0] WS_ACTIVE   = 3'd0;
  localparam logic [WS_W-1:0] WS_TO_SBY   = 3'd1;
  localparam logic [WS_W-1:0] WS_ENTERING = 3'd2;
  localparam logic [WS_W-1:0] WS_STANDBY  = 3'd3;
  localparam logic [WS_W-1:0] WS_TO_ACT   = 3'd4;

  localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_NOTOP_FULL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ABN_FULL   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FULL_NOTOP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ABN_NOTOP  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_NOTOP_ABN  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_FULL_ABN   = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    level_t           level;
    logic [WS_W-1:0]  wake;
    logic             deinit_req;
    logic             stop_req;
  } res_t;

endpackage

// ----- sv/svps_band.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svps_band
// sorts one supply sample into full, low, high or abnormal band
// ----------------------------------------------------------------------------
module svps_band (
  input  svps_pkg::sample_t sample,
  input  svps_pkg::thr_t    thr,
  output svps_pkg::band_t   band
);
  import svps_pkg::*;

  // first match wins; gaps between bands keep the last level
  always_comb begin
    band = '{keep: 1'b1, level: LV_ABN};
    if (sample > thr.full_bottom && sample < thr.full_top) begin
      band = '{keep: 1'b0, level: LV_FULL};
    end else if (sample >= thr.min_valid && sample < thr.low_top) begin
      band = '{keep: 1'b0, level: LV_LOW};
    end else if (sample > thr.high_bottom && sample <= thr.max_valid) begin
      band = '{keep: 1'b0, level: LV_HIGH};
    end else if (sample < thr.min_valid || sample > thr.max_valid) begin
      band = '{keep: 1'b0, level: LV_ABN};
    end
  end

endmodule

// ----- sv/svps_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svps_seq
// wake sequencer and supply level tracker with transition actions
// ----------------------------------------------------------------------------
module svps_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  svps_pkg::band_t band,
  input  logic            wake_pin,
  input  logic            deinit_done,
  output svps_pkg::res_t  res
);
  import svps_pkg::*;

  phase_t wake_phase, wake_phase_next;
  level_t supply_level, supply_level_next;

  logic             eval;
  logic             no_change;
  logic             was_notop;
  level_t           new_level;
  logic [ACT_W-1:0] action;
  logic             deinit_req, stop_req;
  logic [WS_W-1:0]  wake_code;

  always_comb begin
    wake_phase_next = wake_phase;
    eval            = 1'b0;
    new_level       = band.level;
    no_change       = band.keep;
    deinit_req      = 1'b0;
    stop_req        = 1'b0;
    case (wake_phase)
      PH_ACTIVE: begin
        eval = 1'b1;
        if (wake_pin) wake_phase_next = PH_TO_SBY;
      end
      PH_TO_SBY: begin
        // forced abnormal on the way down
        eval            = 1'b1;
        new_level       = LV_ABN;
        no_change       = 1'b0;
        wake_phase_next = PH_ENTERING;
      end
      PH_ENTERING: begin
        deinit_req = 1'b1;
        if (deinit_done) begin
          wake_phase_next = PH_STANDBY;
          stop_req        = 1'b1;
        end
      end
      PH_STANDBY: begin
        if (!wake_pin) wake_phase_next = PH_TO_ACT;
      end
      PH_TO_ACT: begin
        eval            = 1'b1;
        wake_phase_next = PH_ACTIVE;
      end
      default: begin
        wake_phase_next = PH_STANDBY;
      end
    endcase
  end

  always_comb begin
    was_notop         = (supply_level == LV_LOW) || (supply_level == LV_HIGH);
    supply_level_next = supply_level;
    action            = ACT_NONE;
    if (eval && !no_change && new_level != supply_level) begin
      supply_level_next = new_level;
      case (new_level)
        LV_FULL: action = was_notop ? ACT_NOTOP_FULL : ACT_ABN_FULL;
        // low to high also reports abn-notop
        LV_LOW, LV_HIGH: action = (supply_level == LV_FULL) ? ACT_FULL_NOTOP : ACT_ABN_NOTOP;
        default: action = was_notop ? ACT_NOTOP_ABN : ACT_FULL_ABN;
      endcase
    end
  end

  always_comb begin
    case (wake_phase_next)
      PH_ACTIVE:   wake_code = WS_ACTIVE;
      PH_TO_SBY:   wake_code = WS_TO_SBY;
      PH_ENTERING: wake_code = WS_ENTERING;
      PH_TO_ACT:   wake_code = WS_TO_ACT;
      default:     wake_code = WS_STANDBY;
    endcase
  end

  assign res = '{action: action, level: supply_level_next, wake: wake_code,
                 deinit_req: deinit_req, stop_req: stop_req};

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_phase   <= PH_STANDBY;
      supply_level <= LV_ABN;
    end else if (step) begin
      wake_phase   <= wake_phase_next;
      supply_level <= supply_level_next;
    end
  end

endmodule

// ----- sv/supply_voltage_power_supervisor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_power_supervisor
// supply band sorting with hysteresis and a standby/wake sequencer
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A beat is registered, then sorted and
// sequenced and captured in the result register once that register is free,
// and a new beat is taken every cycle while out_stall is low: the only loop
// is the wake phase and supply level state, which is updated once per beat.
// While a result waits under out_stall the input register still takes one
// beat, and the beat after it is stalled. Threshold registers are written
// through cfg_write / cfg_index / cfg_data; the user must do so only while no
// beat is in flight, which the block itself does not enforce. Data bits above
// ADC_BITS are dropped, and the sample is masked the same way.
module supply_voltage_power_supervisor #(
  parameter int ADC_BITS = svps_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [svps_pkg::SAMPLE_W-1:0]     adc_sample,
  input  logic                              wake_pin,
  input  logic                              deinit_done,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svps_pkg::ACT_W-1:0]        transition_action,
  output logic [1:0]                        voltage_level,
  output logic [svps_pkg::WS_W-1:0]         wake_state,
  output logic                              deinit_request,
  output logic                              stop_request,
  // configuration write port
  input  logic                              cfg_write,
  input  logic [svps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svps_pkg::SAMPLE_W-1:0]     cfg_data
);
  import svps_pkg::*;

  // effective converter bits; fields wider than the port are capped
  localparam int EFF_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam sample_t ADC_MASK = sample_t'((1 << EFF_W) - 1);

  // threshold registers
  thr_t thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.min_valid   <= RST_MIN_VALID;
      thr.low_top     <= RST_LOW_TOP;
      thr.full_bottom <= RST_FULL_BOTTOM;
      thr.full_top    <= RST_FULL_TOP;
      thr.high_bottom <= RST_HIGH_BOTTOM;
      thr.max_valid   <= RST_MAX_VALID;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_VALID:   thr.min_valid   <= cfg_data & ADC_MASK;
        REG_LOW_TOP:     thr.low_top     <= cfg_data & ADC_MASK;
        REG_FULL_BOTTOM: thr.full_bottom <= cfg_data & ADC_MASK;
        REG_FULL_TOP:    thr.full_top    <= cfg_data & ADC_MASK;
        REG_HIGH_BOTTOM: thr.high_bottom <= cfg_data & ADC_MASK;
        REG_MAX_VALID:   thr.max_valid   <= cfg_data & ADC_MASK;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // handshake: input register s1, result register on the output
  logic    s1_valid;
  sample_t s1_sample;
  logic    s1_wake, s1_done;
  logic    out_load;
  logic    in_take;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !out_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample <= adc_sample & ADC_MASK;
      s1_wake   <= wake_pin;
      s1_done   <= deinit_done;
    end
  end

  // band sort and sequencer, state advances once per beat
  band_t band;
  res_t  res;

  svps_band u_band (
    .sample (s1_sample),
    .thr    (thr),
    .band   (band)
  );

  svps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (out_load),
    .band        (band),
    .wake_pin    (s1_wake),
    .deinit_done (s1_done),
    .res         (res)
  );

  // result register
  res_t res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign transition_action = res_q.action;
  assign voltage_level     = res_q.level;
  assign wake_state        = res_q.wake;
  assign deinit_request    = res_q.deinit_req;
  assign stop_request      = res_q.stop_req;

endmodule

// ----- tb/supply_voltage_power_supervisor_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_power_supervisor_test
// self-checking bench for the supply band sorter and standby/wake sequencer
// ----------------------------------------------------------------------------
// Every accepted tick runs through a local model of the band sort, the
// hysteresis and the wake phases, and the expected result beat is queued.
// Result beats are compared field by field in order. The run covers the reset
// thresholds with directed ticks, then several threshold sets (extremes,
// sorted random and unordered random) with random ticks, random gaps on both
// channels, one long receiver hold-off and drains before every register write.
module supply_voltage_power_supervisor_test;
  import svps_pkg::*;

  localparam int HOLD_OFF_CYCLES = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_PRINTED = 40;

  // model of the supervisor plus the queue of result beats still owed
  class tick_scoreboard;
    thr_t thr;
    logic [WS_W-1:0] phase;
    level_t level;
    res_t expected_ticks[$];
    int errors;

    function new();
      thr.min_valid = RST_MIN_VALID;
      thr.low_top = RST_LOW_TOP;
      thr.full_bottom = RST_FULL_BOTTOM;
      thr.full_top = RST_FULL_TOP;
      thr.high_bottom = RST_HIGH_BOTTOM;
      thr.max_valid = RST_MAX_VALID;
      phase = WS_STANDBY;
      level = LV_ABN;
      errors = 0;
    endfunction

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, sample_t val);
      case (idx)
        REG_MIN_VALID:   thr.min_valid = val;
        REG_LOW_TOP:     thr.low_top = val;
        REG_FULL_BOTTOM: thr.full_bottom = val;
        REG_FULL_TOP:    thr.full_top = val;
        REG_HIGH_BOTTOM: thr.high_bottom = val;
        REG_MAX_VALID:   thr.max_valid = val;
        default: ;
      endcase
    endfunction

    // first matching band wins, anything left over keeps the level
    function band_t sort_band(sample_t s);
      band_t b;
      b.keep = 1'b0;
      b.level = LV_ABN;
      if (s > thr.full_bottom && s < thr.full_top) b.level = LV_FULL;
      else if (s >= thr.min_valid && s < thr.low_top) b.level = LV_LOW;
      else if (s > thr.high_bottom && s <= thr.max_valid) b.level = LV_HIGH;
      else if (s < thr.min_valid || s > thr.max_valid) b.level = LV_ABN;
      else b.keep = 1'b1;
      return b;
    endfunction

    // moves the level and returns the transition action
    function logic [ACT_W-1:0] move_level(band_t b);
      logic was_notop;
      logic [ACT_W-1:0] act;
      was_notop = (level == LV_LOW || level == LV_HIGH);
      if (b.keep || b.level == level) return ACT_NONE;
      case (b.level)
        LV_FULL: act = was_notop ? ACT_NOTOP_FULL : ACT_ABN_FULL;
        LV_LOW, LV_HIGH: act = (level == LV_FULL) ? ACT_FULL_NOTOP : ACT_ABN_NOTOP;
        default: act = was_notop ? ACT_NOTOP_ABN : ACT_FULL_ABN;
      endcase
      level = b.level;
      return act;
    endfunction

    function void note_tick(sample_t s, logic wake, logic done);
      res_t r;
      band_t forced;
      r = '0;
      forced.keep = 1'b0;
      forced.level = LV_ABN;
      case (phase)
        WS_ACTIVE: begin
          r.action = move_level(sort_band(s));
          if (wake) phase = WS_TO_SBY;
        end
        WS_TO_SBY: begin
          r.action = move_level(forced);
          phase = WS_ENTERING;
        end
        WS_ENTERING: begin
          r.deinit_req = 1'b1;
          if (done) begin
            phase = WS_STANDBY;
            r.stop_req = 1'b1;
          end
        end
        WS_STANDBY: begin
          if (!wake) phase = WS_TO_ACT;
        end
        WS_TO_ACT: begin
          r.action = move_level(sort_band(s));
          phase = WS_ACTIVE;
        end
        default: phase = WS_STANDBY;
      endcase
      r.level = level;
      r.wake = phase;
      expected_ticks.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTED)
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_tick(res_t got);
      res_t want;
      if (expected_ticks.size() == 0) begin
        report_mismatch("result beat with nothing pending", 1, 0);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.action !== want.action)
        report_mismatch("transition_action", int'(got.action), int'(want.action));
      if (got.level !== want.level)
        report_mismatch("voltage_level", int'(got.level), int'(want.level));
      if (got.wake !== want.wake)
        report_mismatch("wake_state", int'(got.wake), int'(want.wake));
      if (got.deinit_req !== want.deinit_req)
        report_mismatch("deinit_request", int'(got.deinit_req), int'(want.deinit_req));
      if (got.stop_req !== want.stop_req)
        report_mismatch("stop_request", int'(got.stop_req), int'(want.stop_req));
    endtask

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [SAMPLE_W-1:0] adc_sample;
  logic wake_pin;
  logic deinit_done;
  logic out_valid;
  logic out_stall;
  logic [ACT_W-1:0] transition_action;
  logic [1:0] voltage_level;
  logic [WS_W-1:0] wake_state;
  logic deinit_request;
  logic stop_request;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0] cfg_data;

  tick_scoreboard sb;
  bit hold_off_req;
  logic wake_level;
  int quiet_cycles;

  supply_voltage_power_supervisor DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .adc_sample(adc_sample),
    .wake_pin(wake_pin),
    .deinit_done(deinit_done),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .transition_action(transition_action),
    .voltage_level(voltage_level),
    .wake_state(wake_state),
    .deinit_request(deinit_request),
    .stop_request(stop_request),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both channels sampled at the rising edge; input beats are noted first so
  // that a result never arrives before its expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_tick(adc_sample, wake_pin, deinit_done);
      if (out_valid && !out_stall)
        sb.check_tick(res_t'({transition_action, voltage_level, wake_state,
                              deinit_request, stop_request}));
    end
  end

  // watchdog: too long without any beat on either channel ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: alternating free and stalled stretches, plus one long hold-off
  // on request; one assignment of out_stall per stretch, made at a falling edge
  initial begin
    int len;
    int r;
    bit stalled;
    out_stall = 1'b0;
    stalled = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        // long hold-off so that the block fills up and stalls its input
        hold_off_req = 1'b0;
        stalled = 1'b1;
        len = HOLD_OFF_CYCLES;
      end else begin
        stalled = !stalled;
        r = $urandom_range(0, 99);
        if (stalled) begin
          if (r < 70) len = $urandom_range(1, 2);
          else if (r < 95) len = $urandom_range(3, 8);
          else len = $urandom_range(15, 30);
        end else begin
          if (r < 50) len = $urandom_range(1, 6);
          else if (r < 90) len = $urandom_range(7, 40);
          else len = $urandom_range(60, 150);
        end
      end
      out_stall <= stalled;
      // a hold-off request cuts the current stretch short
      repeat (len) begin
        @(negedge clk);
        if (hold_off_req) break;
      end
    end
  end

  // sender gap after a beat: mostly none, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // samples cluster around the thresholds in force, with rails and noise
  function automatic sample_t pick_sample();
    int r;
    sample_t base;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? sample_t'(4095) : sample_t'(0);
    if (r < 55) begin
      case ($urandom_range(0, 5))
        0: base = sb.thr.min_valid;
        1: base = sb.thr.low_top;
        2: base = sb.thr.full_bottom;
        3: base = sb.thr.full_top;
        4: base = sb.thr.high_bottom;
        default: base = sb.thr.max_valid;
      endcase
      return sample_t'(int'(base) + $urandom_range(0, 4) - 2);
    end
    return sample_t'($urandom_range(0, 4095));
  endfunction

  // wake pin held in long runs so the sequencer walks through every phase,
  // with an occasional single-tick glitch
  function automatic logic next_wake();
    if ($urandom_range(0, 14) == 0) wake_level = !wake_level;
    if ($urandom_range(0, 19) == 0) return !wake_level;
    return wake_level;
  endfunction

  function automatic thr_t sorted_thresholds();
    int v[$];
    thr_t t;
    repeat (6) v.push_back($urandom_range(0, 4095));
    v.sort();
    t.min_valid = (v[0] == 0) ? sample_t'(1) : sample_t'(v[0]);
    t.low_top = sample_t'(v[1]);
    t.full_bottom = sample_t'(v[2]);
    t.full_top = sample_t'(v[3]);
    t.high_bottom = sample_t'(v[4]);
    t.max_valid = sample_t'(v[5]);
    return t;
  endfunction

  function automatic thr_t unordered_thresholds();
    thr_t t;
    t.min_valid = sample_t'($urandom_range(1, 4095));
    t.low_top = sample_t'($urandom_range(0, 4095));
    t.full_bottom = sample_t'($urandom_range(0, 4095));
    t.full_top = sample_t'($urandom_range(0, 4095));
    t.high_bottom = sample_t'($urandom_range(0, 4095));
    t.max_valid = sample_t'($urandom_range(0, 4095));
    return t;
  endfunction

  // one input beat; called and returns at a falling edge
  task automatic send_tick(sample_t s, logic w, logic d, int gap);
    in_valid <= 1'b1;
    adc_sample <= s;
    wake_pin <= w;
    deinit_done <= d;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_random(int n);
    repeat (n) send_tick(pick_sample(), next_wake(), $urandom_range(0, 99) < 40, pick_gap());
  endtask

  // stop offering, let every owed beat arrive, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, sample_t val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_threshold(idx, val);
    @(negedge clk);
  endtask

  // registers change only with the block idle
  task automatic load_thresholds(thr_t t);
    drain();
    cfg_beat(REG_MIN_VALID, t.min_valid);
    cfg_beat(REG_LOW_TOP, t.low_top);
    cfg_beat(REG_FULL_BOTTOM, t.full_bottom);
    cfg_beat(REG_FULL_TOP, t.full_top);
    cfg_beat(REG_HIGH_BOTTOM, t.high_bottom);
    cfg_beat(REG_MAX_VALID, t.max_valid);
    cfg_write <= 1'b0;
  endtask

  initial begin
    thr_t t;
    sb = new();
    hold_off_req = 1'b0;
    wake_level = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    adc_sample = '0;
    wake_pin = 1'b0;
    deinit_done = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed walk with reset thresholds: starts in standby, abnormal
    send_tick(sample_t'(0), 1'b1, 1'b0, pick_gap());     // standby held by wake pin
    send_tick(sample_t'(4095), 1'b0, 1'b1, pick_gap());  // standby -> to active
    send_tick(sample_t'(2000), 1'b0, 1'b0, pick_gap());  // abnormal -> full
    send_tick(RST_FULL_BOTTOM, 1'b0, 1'b0, pick_gap());  // gap edge, level kept
    send_tick(sample_t'(RST_LOW_TOP - 1), 1'b0, 1'b0, pick_gap());      // full -> low
    send_tick(RST_MIN_VALID, 1'b0, 1'b0, pick_gap());    // low edge, no change
    send_tick(sample_t'(RST_MIN_VALID - 1), 1'b0, 1'b0, pick_gap());    // low -> abnormal
    send_tick(RST_MAX_VALID, 1'b0, 1'b0, pick_gap());    // abnormal -> high
    send_tick(RST_LOW_TOP, 1'b0, 1'b0, pick_gap());      // hysteresis gap
    send_tick(RST_MIN_VALID, 1'b0, 1'b0, pick_gap());    // high -> low reported as abn-notop
    send_tick(sample_t'(RST_FULL_BOTTOM + 1), 1'b0, 1'b0, pick_gap());  // low -> full
    send_tick(sample_t'(RST_MAX_VALID + 1), 1'b0, 1'b0, pick_gap());    // full -> abnormal
    send_tick(sample_t'(RST_FULL_TOP - 1), 1'b0, 1'b0, pick_gap());     // abnormal -> full
    send_tick(RST_FULL_TOP, 1'b0, 1'b0, pick_gap());     // upper gap, kept
    send_tick(RST_HIGH_BOTTOM, 1'b0, 1'b0, pick_gap());  // upper gap, kept
    send_tick(sample_t'(RST_HIGH_BOTTOM + 1), 1'b0, 1'b0, pick_gap());  // full -> high
    send_tick(sample_t'(4095), 1'b0, 1'b0, pick_gap());  // high -> abnormal
    send_tick(sample_t'(2000), 1'b1, 1'b1, pick_gap());  // -> full, wake asks standby
    send_tick(sample_t'(2000), 1'b0, 1'b1, pick_gap());  // forced abnormal
    send_tick(sample_t'(0), 1'b1, 1'b0, pick_gap());     // entering, deinit pending
    send_tick(sample_t'(4095), 1'b0, 1'b0, pick_gap());  // still entering
    send_tick(sample_t'(1), 1'b1, 1'b1, pick_gap());     // deinit done -> stop, standby
    send_tick(sample_t'(2000), 1'b0, 1'b0, pick_gap());  // standby -> to active
    send_tick(RST_MIN_VALID, 1'b1, 1'b0, pick_gap());    // to active ignores wake pin
    run_random(200);

    // receiver holds off while the sender keeps offering back to back
    hold_off_req = 1'b1;
    repeat (30) send_tick(pick_sample(), next_wake(), 1'($urandom_range(0, 1)), 0);
    // sender pauses until every owed beat is back
    drain();
    run_random(50);

    // top extreme: everything below the minimum is abnormal
    t.min_valid = sample_t'(4095);
    t.low_top = sample_t'(4095);
    t.full_bottom = sample_t'(4095);
    t.full_top = sample_t'(4095);
    t.high_bottom = sample_t'(4095);
    t.max_valid = sample_t'(4095);
    load_thresholds(t);
    run_random(100);

    // bottom extreme: zero is below minimum, anything else above maximum
    t.min_valid = sample_t'(1);
    t.low_top = sample_t'(0);
    t.full_bottom = sample_t'(0);
    t.full_top = sample_t'(0);
    t.high_bottom = sample_t'(0);
    t.max_valid = sample_t'(0);
    load_thresholds(t);
    run_random(100);

    repeat (4) begin
      load_thresholds(sorted_thresholds());
      run_random(180);
    end
    repeat (2) begin
      load_thresholds(unordered_thresholds());
      run_random(120);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
